FILE: hdl/bpc_pkg.sv
// bpc_pkg: shared types and constants of the button press classifier.
// Transfer payloads, per-pin state word, event codes, register map.
// No dependencies.
package bpc_pkg;

    // Event and flag codes share one encoding
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_PRESS     = 3'd1,
        EV_LONG      = 3'd2,
        EV_REL_SHORT = 3'd3,
        EV_REL_LONG  = 3'd4
    } event_code_t;

    // Item function codes
    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_CONSUME = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_ENABLE   = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST = 16'd120;
    localparam logic [15:0] LONG_RST     = 16'd1000;
    localparam logic [15:0] ENABLE_RST   = 16'd0;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef struct packed {
        logic        func;
        logic [3:0]  pin_index;
        logic        level;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0] pin_out;
        logic [2:0] event_res;
        logic [2:0] pin_flag_out;
        logic       level_out;
    } out_item_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_ms;
        logic [15:0] input_enable;
    } cfg_t;

    // One pin's state word as held in the state RAM
    typedef struct packed {
        logic        level;
        event_code_t flag;
        logic [31:0] press_start;
        logic        timing;
    } pin_state_t;

    localparam int STATE_W = $bits(pin_state_t);

    localparam pin_state_t STATE_RST = '{
        level:       1'b1,
        flag:        EV_NONE,
        press_start: 32'd0,
        timing:      1'b0
    };

endpackage

FILE: hdl/bpc_ram.sv
// bpc_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

FILE: hdl/bpc_cfg.sv
// bpc_cfg: APB register block (debounce, long-press time, enable mask).
// Depends on bpc_pkg.
module bpc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [bpc_pkg::PDATA_W-1:0]  pwdata,
    output logic [bpc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bpc_pkg::cfg_t                cfg
);

    logic [15:0] debounce_reg;
    logic [15:0] long_reg;
    logic [15:0] enable_reg;
    logic        wr_fire;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= bpc_pkg::DEBOUNCE_RST;
            long_reg     <= bpc_pkg::LONG_RST;
            enable_reg   <= bpc_pkg::ENABLE_RST;
        end
        else if (wr_fire)
        begin
            case (reg_idx)
                bpc_pkg::REG_DEBOUNCE: debounce_reg <= pwdata[15:0];
                bpc_pkg::REG_LONG:     long_reg     <= pwdata[15:0];
                bpc_pkg::REG_ENABLE:   enable_reg   <= pwdata[15:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            bpc_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            bpc_pkg::REG_LONG:     prdata = {16'd0, long_reg};
            bpc_pkg::REG_ENABLE:   prdata = {16'd0, enable_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.debounce_ms  = debounce_reg;
    assign cfg.long_ms      = long_reg;
    assign cfg.input_enable = enable_reg;

endmodule

FILE: hdl/bpc_update.sv
// bpc_update: modify step of the read-modify-write; classifies one sample.
// Depends on bpc_pkg.
module bpc_update (
    input  bpc_pkg::in_item_t   item,
    input  bpc_pkg::pin_state_t cur,
    input  bpc_pkg::cfg_t       cfg,
    input  logic                in_range,
    output bpc_pkg::pin_state_t nxt,
    output bpc_pkg::out_item_t  result
);

    logic [31:0]          held;
    logic                 enabled;
    bpc_pkg::event_code_t ev;

    assign held    = item.now_ms - cur.press_start;   // wraps mod 2^32
    assign enabled = cfg.input_enable[item.pin_index];

    always_comb
    begin
        nxt = cur;
        ev  = bpc_pkg::EV_NONE;
        if (item.func == bpc_pkg::FUNC_CONSUME)
        begin
            nxt.flag = bpc_pkg::EV_NONE;
        end
        else if (enabled)
        begin
            if (!item.level)
            begin
                if (cur.level)
                begin
                    // falling edge: start timing
                    nxt.level       = 1'b0;
                    nxt.press_start = item.now_ms;
                    nxt.timing      = 1'b1;
                end
                else if (cur.timing)
                begin
                    if (cur.flag != bpc_pkg::EV_PRESS && held > {16'd0, cfg.debounce_ms})
                    begin
                        nxt.flag = bpc_pkg::EV_PRESS;
                        ev       = bpc_pkg::EV_PRESS;
                    end
                    else if (cur.flag == bpc_pkg::EV_PRESS && held > {16'd0, cfg.long_ms})
                    begin
                        nxt.flag   = bpc_pkg::EV_LONG;
                        nxt.timing = 1'b0;
                        ev         = bpc_pkg::EV_LONG;
                    end
                end
            end
            else if (!cur.level)
            begin
                nxt.level  = 1'b1;
                nxt.timing = 1'b0;
                if (cur.flag == bpc_pkg::EV_PRESS)
                begin
                    nxt.flag = bpc_pkg::EV_REL_SHORT;
                    ev       = bpc_pkg::EV_REL_SHORT;
                end
                else if (cur.flag == bpc_pkg::EV_LONG)
                begin
                    nxt.flag = bpc_pkg::EV_REL_LONG;
                    ev       = bpc_pkg::EV_REL_LONG;
                end
            end
        end
    end

    always_comb
    begin
        result.pin_out = item.pin_index;
        if (in_range)
        begin
            result.event_res    = ev;
            result.pin_flag_out = nxt.flag;
            result.level_out    = nxt.level;
        end
        else
        begin
            result.event_res    = bpc_pkg::EV_NONE;
            result.pin_flag_out = bpc_pkg::EV_NONE;
            result.level_out    = 1'b1;
        end
    end

endmodule

FILE: hdl/button_press_classifier.sv
// button_press_classifier: top level; state RAM, pipeline and output register.
// Depends on bpc_pkg, bpc_ram, bpc_cfg, bpc_update.
//
//   Channel   Handshake              Payload / signals
//   -------   --------------------   ------------------------------------
//   input     in_valid / in_stall    in_item  (bpc_pkg::in_item_t)
//   output    out_valid / out_stall  out_item (bpc_pkg::out_item_t)
//   config    psel/penable/pready    paddr, pwrite, pwdata, prdata (APB)
//
// One item per cycle sustained while the output is not stalled. The request stage
// reads the pin's state word from the state RAM; the classify stage classifies,
// writes back and loads the output register. The RAM read port sets the rate.
// A write-back to the pin just read is forwarded, so a pin can repeat every cycle.
// Reset clears the per-entry valid bits at once (an entry not yet written reads
// as released/no flag), so no clearing pass is needed and items are taken at once.
// in_stall rises only when the classify stage is full and the result is stalled.
module button_press_classifier #(
    parameter int NUM_PINS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  bpc_pkg::in_item_t            in_item,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output bpc_pkg::out_item_t           out_item,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [bpc_pkg::PDATA_W-1:0]  pwdata,
    output logic [bpc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int         AW      = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam logic [6:0] NPINS_W = 7'(NUM_PINS);

    bpc_pkg::cfg_t cfg;

    // request stage (RAM address phase)
    logic          in_fire;
    logic [6:0]    in_pin_ext;
    logic [AW-1:0] in_addr;
    logic          in_range;

    // classify stage
    logic                s1_valid_reg;
    bpc_pkg::in_item_t   s1_item_reg;
    logic                s1_range_reg;
    logic                s1_vld_reg;     // entry written since reset
    logic                fwd_hit_reg;    // same entry written as it was read
    bpc_pkg::pin_state_t fwd_data_reg;
    logic                s1_adv;
    logic                s1_fire;
    logic [6:0]          s1_pin_ext;
    logic [AW-1:0]       s1_addr;

    logic [bpc_pkg::STATE_W-1:0] ram_rd_data;
    bpc_pkg::pin_state_t         cur_state;
    bpc_pkg::pin_state_t         nxt_state;
    bpc_pkg::out_item_t          result;
    logic                        wr_en;

    logic [NUM_PINS-1:0] vld_reg;

    logic               out_valid_reg;
    bpc_pkg::out_item_t out_item_reg;

    bpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshakes
    assign s1_adv   = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_fire  = in_valid && !in_stall;

    assign in_pin_ext = {3'd0, in_item.pin_index};
    assign in_addr    = in_pin_ext[AW-1:0];
    assign in_range   = in_pin_ext < NPINS_W;

    assign s1_pin_ext = {3'd0, s1_item_reg.pin_index};
    assign s1_addr    = s1_pin_ext[AW-1:0];
    assign wr_en      = s1_fire && s1_range_reg;

    bpc_ram #(
        .WIDTH (bpc_pkg::STATE_W),
        .DEPTH (NUM_PINS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (nxt_state),
        .rd_en   (in_fire),
        .rd_addr (in_addr),
        .rd_data (ram_rd_data)
    );

    // forwarded write wins, then RAM data, else reset value
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_state = fwd_data_reg;
        end
        else if (s1_vld_reg)
        begin
            cur_state = bpc_pkg::pin_state_t'(ram_rd_data);
        end
        else
        begin
            cur_state = bpc_pkg::STATE_RST;
        end
    end

    bpc_update u_update (
        .item     (s1_item_reg),
        .cur      (cur_state),
        .cfg      (cfg),
        .in_range (s1_range_reg),
        .nxt      (nxt_state),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (wr_en)
            begin
                vld_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg  <= in_item;
            s1_range_reg <= in_range;
            s1_vld_reg   <= in_range && vld_reg[in_addr];
            fwd_hit_reg  <= wr_en && in_range && (s1_addr == in_addr);
            fwd_data_reg <= nxt_state;
        end
        if (s1_fire)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // a reported event is always the flag left behind
    a_event_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.event_res != bpc_pkg::EV_NONE
        |-> out_item.pin_flag_out == out_item.event_res)
        else $error("event code differs from stored flag");

    // press events leave the pin low, release events leave it high
    a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.event_res == bpc_pkg::EV_PRESS
                      || out_item.event_res == bpc_pkg::EV_LONG)
        |-> !out_item.level_out)
        else $error("press event with released level");

    a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.event_res == bpc_pkg::EV_REL_SHORT
                      || out_item.event_res == bpc_pkg::EV_REL_LONG)
        |-> out_item.level_out)
        else $error("release event with pressed level");

    // input is only held off by a full classify stage
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with pipeline free");

endmodule
